@@ hdl/pms_pkg.sv @@
package pms_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int LUT_ADDR_BITS = 10;
    localparam int LUT_SIZE      = 1 << LUT_ADDR_BITS;
    localparam int LUT_LAST      = LUT_SIZE - 1;
    localparam int FS_INT        = (1 << SAMPLE_BITS) - 1;
    localparam int MID_LO_INT    = (FS_INT + 999) / 1000;
    localparam int LOG_GAIN      = 500;
    localparam int ASINH_GAIN    = 50;
    localparam int LOG2_FRAC     = 30;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LUT_ADDR_BITS-1:0] lut_addr_t;
    typedef sample_t rom_t [LUT_SIZE];

    localparam sample_t FULL_SCALE = SAMPLE_BITS'(FS_INT);
    localparam sample_t HALF_SCALE = SAMPLE_BITS'((FS_INT + 1) / 2);
    localparam sample_t MID_LO     = SAMPLE_BITS'(MID_LO_INT);
    localparam sample_t MID_HI     = SAMPLE_BITS'(FS_INT - MID_LO_INT);

    // Pipeline depths of the three processing sections.
    localparam int WIN_STEPS = SAMPLE_BITS;
    localparam int WIN_LAT   = WIN_STEPS + 1;
    localparam int SHAPE_LAT = 3;
    localparam int MTF_STEPS = SAMPLE_BITS;
    localparam int MTF_LAT   = MTF_STEPS + 3;
    localparam int PIPE_LAT  = WIN_LAT + SHAPE_LAT + MTF_LAT;

    typedef enum logic [1:0] {
        REG_BLACK   = 2'd0,
        REG_WHITE   = 2'd1,
        REG_MIDTONE = 2'd2,
        REG_SHAPE   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        SHAPE_LINEAR = 2'd0,
        SHAPE_LOG    = 2'd1,
        SHAPE_ASINH  = 2'd2
    } shape_mode_t;

    // Fixed-point log2 with LOG2_FRAC fraction bits, by repeated squaring.
    function automatic logic [63:0] log2q(logic [63:0] v);
        int e;
        logic [63:0] m;
        logic [63:0] r;
        e = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) e = i;
        end
        m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
        r = 64'(e) << LOG2_FRAC;
        for (int k = LOG2_FRAC - 1; k >= 0; k--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                r[k] = 1'b1;
            end
        end
        if (v == 64'd0) r = 64'd0;
        return r;
    endfunction

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = 64'd0;
        b = 64'd1 << 62;
        x = v;
        for (int i = 0; i < 32; i++) begin
            if (b > x) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] asinh_arg(logic [63:0] i);
        logic [63:0] sq;
        sq = 64'(ASINH_GAIN * ASINH_GAIN) * i * i + 64'(LUT_LAST) * 64'(LUT_LAST);
        return 64'(ASINH_GAIN) * i * 64'd256 + isqrt64(sq << 16);
    endfunction

    // floor(num * FS / span) saturated, as a shift-subtract long division.
    function automatic sample_t rom_scale(logic [63:0] num, logic [63:0] span);
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] rem;
        p = num * 64'(FS_INT);
        q = 64'd0;
        rem = 64'd0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[62:0], p[k]};
            if (rem >= span) begin
                rem = rem - span;
                q[k] = 1'b1;
            end
        end
        if (span == 64'd0) q = 64'd0;
        if (q > 64'(FS_INT)) q = 64'(FS_INT);
        return SAMPLE_BITS'(q);
    endfunction

    // Curve table: sel 0 gives log1p, sel 1 gives asinh.
    function automatic rom_t build_rom(logic sel);
        rom_t tbl;
        logic [63:0] lbase;
        logic [63:0] lspan;
        logic [63:0] abase;
        logic [63:0] aspan;
        lbase = log2q(64'(LUT_LAST));
        lspan = log2q(64'(LUT_LAST) * 64'(LOG_GAIN + 1)) - lbase;
        abase = log2q(asinh_arg(64'd0));
        aspan = log2q(asinh_arg(64'(LUT_LAST))) - abase;
        for (int i = 0; i < LUT_SIZE; i++) begin
            if (sel) begin
                tbl[i] = rom_scale(log2q(asinh_arg(64'(i))) - abase, aspan);
            end else begin
                tbl[i] = rom_scale(log2q(64'(LUT_LAST) + 64'(LOG_GAIN) * 64'(i)) - lbase,
                                   lspan);
            end
        end
        return tbl;
    endfunction

endpackage

@@ hdl/pms_window.sv @@
module pms_window
    import pms_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  sample_t v,
    input  sample_t black,
    input  sample_t white,
    output sample_t t
);

    sample_t rem_reg  [WIN_STEPS+1];
    sample_t low_reg  [WIN_STEPS+1];
    sample_t quo_reg  [WIN_STEPS+1];
    sample_t den_reg  [WIN_STEPS+1];
    logic    zero_reg [WIN_STEPS+1];
    logic    sat_reg  [WIN_STEPS+1];

    sample_t rem_next [WIN_STEPS+1];
    logic    ge_next  [WIN_STEPS+1];

    sample_t                  d;
    sample_t                  den;
    logic [2*SAMPLE_BITS-1:0] num;

    // Prep: offset, divisor and the scaled numerator d * FS.
    always_comb
    begin
        d   = v - black;
        den = (white > black) ? (white - black) : sample_t'(1);
        num = {d, {SAMPLE_BITS{1'b0}}} - (2*SAMPLE_BITS)'(d);
    end

    // One quotient bit per stage; the remainder stays below den unless d >= den, where the result saturates.
    always_comb
    begin
        rem_next[0] = '0;
        ge_next[0]  = 1'b0;
        for (int k = 1; k <= WIN_STEPS; k++)
        begin
            logic [SAMPLE_BITS:0] sh;
            sh          = {rem_reg[k-1], low_reg[k-1][SAMPLE_BITS-1]};
            ge_next[k]  = (sh >= (SAMPLE_BITS+1)'(den_reg[k-1]));
            rem_next[k] = ge_next[k] ? SAMPLE_BITS'(sh - (SAMPLE_BITS+1)'(den_reg[k-1]))
                                     : sh[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num[2*SAMPLE_BITS-1:SAMPLE_BITS];
            low_reg[0]  <= num[SAMPLE_BITS-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            zero_reg[0] <= (v <= black);
            sat_reg[0]  <= (d >= den);
            for (int k = 1; k <= WIN_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= {low_reg[k-1][SAMPLE_BITS-2:0], 1'b0};
                quo_reg[k]  <= {quo_reg[k-1][SAMPLE_BITS-2:0], ge_next[k]};
                den_reg[k]  <= den_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end
    end

    assign t = zero_reg[WIN_STEPS] ? '0 :
               sat_reg[WIN_STEPS]  ? FULL_SCALE : quo_reg[WIN_STEPS];

endmodule

@@ hdl/pms_shape.sv @@
module pms_shape
    import pms_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  sample_t    t,
    input  logic [1:0] mode,
    output sample_t    s
);

    localparam rom_t LOG_ROM   = build_rom(1'b0);
    localparam rom_t ASINH_ROM = build_rom(1'b1);

    lut_addr_t  idx_reg;
    sample_t    t1_reg;
    logic [1:0] mode1_reg;
    sample_t    log_data_reg;
    sample_t    asinh_data_reg;
    sample_t    t2_reg;
    logic [1:0] mode2_reg;
    sample_t    s_reg;

    logic [SAMPLE_BITS+LUT_ADDR_BITS-1:0] y;
    logic [SAMPLE_BITS:0]                 r;
    lut_addr_t                            idx_next;
    sample_t                              s_next;

    // Table index floor(t * LUT_LAST / FS), FS being 2^n - 1.
    always_comb
    begin
        y        = {t, {LUT_ADDR_BITS{1'b0}}} - (SAMPLE_BITS+LUT_ADDR_BITS)'(t);
        idx_next = y[SAMPLE_BITS+LUT_ADDR_BITS-1:SAMPLE_BITS];
        r        = (SAMPLE_BITS+1)'(y[SAMPLE_BITS-1:0]) + (SAMPLE_BITS+1)'(idx_next);
        if (r >= (SAMPLE_BITS+1)'(FULL_SCALE))
        begin
            idx_next = idx_next + lut_addr_t'(1);
        end
    end

    always_comb
    begin
        case (mode2_reg)
            SHAPE_LOG:   s_next = log_data_reg;
            SHAPE_ASINH: s_next = asinh_data_reg;
            default:     s_next = t2_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg        <= idx_next;
            t1_reg         <= t;
            mode1_reg      <= mode;
            log_data_reg   <= LOG_ROM[idx_reg];
            asinh_data_reg <= ASINH_ROM[idx_reg];
            t2_reg         <= t1_reg;
            mode2_reg      <= mode1_reg;
            s_reg          <= s_next;
        end
    end

    assign s = s_reg;

endmodule

@@ hdl/pms_mtf.sv @@
module pms_mtf
    import pms_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  sample_t s,
    input  sample_t m,
    output sample_t pix
);

    localparam int PW = 2 * SAMPLE_BITS;
    localparam int NW = 3 * SAMPLE_BITS;
    localparam int DW = 2 * SAMPLE_BITS + 1;

    typedef struct packed {
        logic zero;
        logic full;
        logic half;
        logic sat;
    } mtf_flags_t;

    // Products stage.
    sample_t        s_p_reg;
    sample_t        m_p_reg;
    logic [PW-1:0]  as_reg;
    logic [PW-1:0]  ms_reg;

    // Numerator and denominator stage.
    logic [NW-1:0]  n_reg;
    logic [DW-1:0]  d_nd_reg;
    mtf_flags_t     fl_nd_reg;

    // Division stages; index 0 is the start of the division.
    logic [DW-1:0]      rem_reg [MTF_STEPS+1];
    sample_t            low_reg [MTF_STEPS+1];
    sample_t            quo_reg [MTF_STEPS+1];
    logic [DW-1:0]      d_reg   [MTF_STEPS+1];
    mtf_flags_t         fl_reg  [MTF_STEPS+1];

    logic [DW-1:0] rem_next [MTF_STEPS+1];
    logic          ge_next  [MTF_STEPS+1];

    logic [SAMPLE_BITS:0] sm;
    logic [DW-1:0]        smf;
    logic [DW-1:0]        d_next;
    mtf_flags_t           fl_next;
    mtf_flags_t           fl_last;

    always_comb
    begin
        sm     = (SAMPLE_BITS+1)'(s_p_reg) + (SAMPLE_BITS+1)'(m_p_reg);
        smf    = {sm, {SAMPLE_BITS{1'b0}}} - DW'(sm);
        d_next = smf - {ms_reg, 1'b0};
        fl_next.zero = (s_p_reg == '0);
        fl_next.full = (s_p_reg == FULL_SCALE);
        fl_next.half = (s_p_reg == m_p_reg);
        fl_next.sat  = 1'b0;
    end

    always_comb
    begin
        rem_next[0] = '0;
        ge_next[0]  = 1'b0;
        for (int k = 1; k <= MTF_STEPS; k++)
        begin
            logic [DW:0] sh;
            sh          = {rem_reg[k-1], low_reg[k-1][SAMPLE_BITS-1]};
            ge_next[k]  = (sh >= {1'b0, d_reg[k-1]});
            rem_next[k] = ge_next[k] ? DW'(sh - {1'b0, d_reg[k-1]}) : sh[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_p_reg   <= s;
            m_p_reg   <= m;
            as_reg    <= PW'(FULL_SCALE - m) * PW'(s);
            ms_reg    <= PW'(m) * PW'(s);

            n_reg     <= {as_reg, {SAMPLE_BITS{1'b0}}} - NW'(as_reg);
            d_nd_reg  <= d_next;
            fl_nd_reg <= fl_next;

            rem_reg[0] <= DW'(n_reg[NW-1:SAMPLE_BITS]);
            low_reg[0] <= n_reg[SAMPLE_BITS-1:0];
            quo_reg[0] <= '0;
            d_reg[0]   <= d_nd_reg;
            fl_reg[0]  <= '{zero: fl_nd_reg.zero, full: fl_nd_reg.full,
                            half: fl_nd_reg.half,
                            sat:  (DW'(n_reg[NW-1:SAMPLE_BITS]) >= d_nd_reg)};
            for (int k = 1; k <= MTF_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= {low_reg[k-1][SAMPLE_BITS-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][SAMPLE_BITS-2:0], ge_next[k]};
                d_reg[k]   <= d_reg[k-1];
                fl_reg[k]  <= fl_reg[k-1];
            end
        end
    end

    assign fl_last = fl_reg[MTF_STEPS];
    assign pix = fl_last.zero ? '0 :
                 fl_last.full ? FULL_SCALE :
                 fl_last.half ? HALF_SCALE :
                 fl_last.sat  ? FULL_SCALE : quo_reg[MTF_STEPS];

endmodule

@@ hdl/pixel_midtone_stretch_unit.sv @@
// Per-pixel midtone stretch.
// Pixels enter on the s_* stream (one 16-bit beat per pixel) and leave on the
// m_* stream in the same order, one result beat per input beat.
// The configuration port writes black, white, midtone and curve mode; write
// it only while no pixel is in flight.
// Throughput is one pixel per cycle while the receiver keeps up. From an
// accepted input beat the result passes the window divider (one quotient
// bit per stage), table index, curve ROM read and curve select, the transfer
// function (products, numerator and denominator, then one quotient bit per
// stage) and the output buffer before it appears on m_tvalid.
// The midtone point is windowed by a second divider lane running beside the
// pixel lane, so it needs no separate setup time.
// Reset restores the default registers and empties the pipeline; the curve
// tables are constants and need no fill time.
// When the receiver stalls, results collect in a two-entry output buffer;
// the pipeline keeps accepting beats until the buffer is full and the last
// stage holds a result, then s_tready drops and the whole pipeline holds.
module pixel_midtone_stretch_unit
    import pms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] pixel_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] pixel_out
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    sample_t    black_reg;
    sample_t    white_reg;
    sample_t    midtone_reg;
    logic [1:0] mode_reg;

    logic [PIPE_LAT-1:0] valid_reg;
    logic                en;

    sample_t t_win;
    sample_t m_win;
    sample_t m_clamp;
    sample_t m_dly_reg [SHAPE_LAT];
    sample_t s_curve;
    sample_t pix;

    sample_t    fifo_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fifo_cnt_reg;
    logic       push;
    logic       pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg   <= '0;
            white_reg   <= FULL_SCALE;
            midtone_reg <= HALF_SCALE;
            mode_reg    <= SHAPE_LINEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BLACK:   black_reg   <= cfg_wdata;
                REG_WHITE:   white_reg   <= cfg_wdata;
                REG_MIDTONE: midtone_reg <= cfg_wdata;
                REG_SHAPE:   mode_reg    <= cfg_wdata[1:0];
                default:     ;
            endcase
        end
    end

    // The whole pipeline moves together; it only holds when the output
    // buffer is full and the last stage carries a result.
    assign en       = !(valid_reg[PIPE_LAT-1] && (fifo_cnt_reg == 2'd2));
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    pms_window u_pix_window (
        .clk   (clk),
        .en    (en),
        .v     (s_tdata),
        .black (black_reg),
        .white (white_reg),
        .t     (t_win)
    );

    pms_window u_mid_window (
        .clk   (clk),
        .en    (en),
        .v     (midtone_reg),
        .black (black_reg),
        .white (white_reg),
        .t     (m_win)
    );

    pms_shape u_shape (
        .clk  (clk),
        .en   (en),
        .t    (t_win),
        .mode (mode_reg),
        .s    (s_curve)
    );

    // Midtone is clamped away from the ends, then delayed to meet the curve.
    assign m_clamp = (m_win < MID_LO) ? MID_LO :
                     (m_win > MID_HI) ? MID_HI : m_win;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_dly_reg[0] <= m_clamp;
            for (int k = 1; k < SHAPE_LAT; k++)
            begin
                m_dly_reg[k] <= m_dly_reg[k-1];
            end
        end
    end

    pms_mtf u_mtf (
        .clk (clk),
        .en  (en),
        .s   (s_curve),
        .m   (m_dly_reg[SHAPE_LAT-1]),
        .pix (pix)
    );

    // Two-entry output buffer.
    assign push = valid_reg[PIPE_LAT-1] && en;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
            end
        end
    end

    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_tdata  = fifo_mem_reg[rd_ptr_reg];

    // A held pipeline keeps its valid bits in place.
    a_hold_stable : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline valid bits moved while held");

    // Input is refused only when the buffer is full and a result waits.
    a_ready_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (fifo_cnt_reg == 2'd2) && valid_reg[PIPE_LAT-1])
        else $error("input refused without a full output buffer");

    // The buffer never goes past two entries.
    a_fifo_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_cnt_reg == 2'd2) && !pop |=> (fifo_cnt_reg == 2'd2) && !push)
        else $error("output buffer overflow");

endmodule

@@ tb/tb_pixel_midtone_stretch_unit.sv @@
`timescale 1ns / 100ps

module tb_pixel_midtone_stretch_unit;
    import pms_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] pixel_in
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] pixel_out
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    pixel_midtone_stretch_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Local copy of the programmed window, midtone and curve selection.
    logic [15:0] black_q;
    logic [15:0] white_q;
    logic [15:0] mid_q;
    logic [1:0]  curve_q;

    // Curve tables, rebuilt here independently of the design.
    logic [15:0] log_curve [LUT_SIZE];
    logic [15:0] asinh_curve [LUT_SIZE];

    sample_t     pending_pixels[$];
    int          mismatch_count;
    bit          idle_on;       // random gaps on both sides
    int          hold_cycles;   // receiver hold-off, counted down per cycle

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------

    // Fixed-point log2 with 30 fraction bits. The mantissa is normalized to
    // [1,2) with 31 fraction bits and each squaring yields one result bit.
    function automatic logic [63:0] fix_log2(logic [63:0] v);
        int          msb;
        logic [63:0] mant;
        logic [63:0] acc;
        msb = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                msb = i;
        end
        if (v == 0)
            return 64'd0;
        if (msb >= 31)
            mant = v >> (msb - 31);
        else
            mant = v << (31 - msb);
        acc = 64'(msb) << LOG2_FRAC;
        for (int k = LOG2_FRAC - 1; k >= 0; k--)
        begin
            mant = (mant * mant) >> 31;
            if (mant >= (64'd1 << 32))
            begin
                mant = mant >> 1;
                acc[k] = 1'b1;
            end
        end
        return acc;
    endfunction

    // Floor square root by bisection.
    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd4294967296;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [63:0] hyp_point(logic [63:0] i);
        logic [63:0] sq;
        sq = 64'd2500 * i * i + 64'(LUT_LAST) * 64'(LUT_LAST);
        return 64'd50 * i * 64'd256 + floor_sqrt(sq << 16);
    endfunction

    function automatic logic [15:0] scale_to_fs(logic [63:0] num, logic [63:0] span);
        logic [63:0] q;
        if (span == 0)
            return 16'd0;
        q = num * 64'(FS_INT) / span;
        return (q > 64'(FS_INT)) ? 16'hFFFF : q[15:0];
    endfunction

    task automatic build_curves();
        logic [63:0] lbase;
        logic [63:0] lspan;
        logic [63:0] abase;
        logic [63:0] aspan;
        lbase = fix_log2(64'(LUT_LAST));
        lspan = fix_log2(64'(LUT_LAST) * 64'd501) - lbase;
        abase = fix_log2(hyp_point(0));
        aspan = fix_log2(hyp_point(64'(LUT_LAST))) - abase;
        for (int i = 0; i < LUT_SIZE; i++)
        begin
            log_curve[i]   = scale_to_fs(fix_log2(64'(LUT_LAST) + 64'd500 * 64'(i)) - lbase,
                                         lspan);
            asinh_curve[i] = scale_to_fs(fix_log2(hyp_point(64'(i))) - abase, aspan);
        end
    endtask

    // Maps a raw value through the black/white window onto full scale.
    function automatic logic [63:0] apply_window(logic [63:0] v);
        logic [63:0] den;
        logic [63:0] q;
        if (v <= 64'(black_q))
            return 64'd0;
        den = (white_q > black_q) ? 64'(white_q - black_q) : 64'd1;
        q = (v - 64'(black_q)) * 64'(FS_INT) / den;
        return (q > 64'(FS_INT)) ? 64'(FS_INT) : q;
    endfunction

    function automatic sample_t stretch_pixel(sample_t pix);
        logic [63:0]  t;
        logic [63:0]  idx;
        logic [63:0]  s;
        logic [63:0]  m;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        t = apply_window(64'(pix));
        idx = t * 64'(LUT_LAST) / 64'(FS_INT);
        if (curve_q == SHAPE_LOG)
            s = 64'(log_curve[idx]);
        else if (curve_q == SHAPE_ASINH)
            s = 64'(asinh_curve[idx]);
        else
            s = t;
        m = apply_window(64'(mid_q));
        if (m < 64'(MID_LO_INT))
            m = 64'(MID_LO_INT);
        if (m > 64'(FS_INT - MID_LO_INT))
            m = 64'(FS_INT - MID_LO_INT);
        if (s == 0)
            return 16'd0;
        if (s >= 64'(FS_INT))
            return 16'hFFFF;
        if (s == m)
            return HALF_SCALE;
        num = 128'((64'(FS_INT) - m) * s) * 128'(FS_INT);
        den = 128'((s + m) * 64'(FS_INT) - 2 * m * s);
        q = num / den;
        return (q > 128'(FS_INT)) ? 16'hFFFF : q[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver side
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Every accepted output beat is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected output beat, pixel_out", m_tdata, -1);
            else
            begin
                sample_t want;
                want = pending_pixels.pop_front();
                if (m_tdata !== want)
                    report_mismatch("pixel_out", m_tdata, want);
            end
        end
    end

    // The receiver stalls at random, and for a long stretch when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (idle_on)
            m_tready <= ($urandom_range(99) >= 32);
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Sender side and configuration
    // ------------------------------------------------------------------

    // Offers one pixel, with random gaps in front, until it is accepted; the
    // prediction is queued at acceptance. tvalid is left high on return.
    task automatic send_pixel(sample_t pix);
        while (idle_on && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        pending_pixels = {pending_pixels, stretch_pixel(pix)};
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (PIPE_LAT + 20) @(posedge clk);
    endtask

    // Writes all four registers back to back while no pixel is in flight.
    task automatic program_stretch(logic [15:0] blk, logic [15:0] wht,
                                   logic [15:0] mid, logic [1:0] curve);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_BLACK;
        cfg_wdata <= blk;
        @(posedge clk);
        cfg_addr  <= REG_WHITE;
        cfg_wdata <= wht;
        @(posedge clk);
        cfg_addr  <= REG_MIDTONE;
        cfg_wdata <= mid;
        @(posedge clk);
        cfg_addr  <= REG_SHAPE;
        cfg_wdata <= 16'(curve);
        @(posedge clk);
        cfg_we <= 1'b0;
        black_q = blk;
        white_q = wht;
        mid_q   = mid;
        curve_q = curve;
    endtask

    // Pixels biased toward the window edges and the midtone, where the
    // saturation and the equal-to-midtone cases sit.
    function automatic sample_t pick_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return sample_t'($urandom);
        else if (r < 65)
            return black_q + sample_t'($urandom_range(3)) - 16'd1;
        else if (r < 75)
            return white_q + sample_t'($urandom_range(3)) - 16'd1;
        else if (r < 85)
            return mid_q + sample_t'($urandom_range(7)) - 16'd3;
        else if (r < 92)
            return sample_t'($urandom_range(255));
        else
            return 16'hFFFF - sample_t'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes under the reset settings, which the predictor assumes.
    task automatic test_reset_defaults();
        sample_t pix [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFE, 16'h5555};
        foreach (pix[i])
            send_pixel(pix[i]);
    endtask

    // Each curve, the unused mode acting as linear, midtone clamps and the
    // empty and inverted windows.
    task automatic test_directed_cases();
        program_stretch(16'h1000, 16'hF000, 16'h4000, SHAPE_LOG);
        send_pixel(16'h0FFF);
        send_pixel(16'h8000);
        send_pixel(16'hF001);
        program_stretch(16'h0000, 16'hFFFF, 16'h0100, SHAPE_ASINH);
        send_pixel(16'h0001);
        send_pixel(16'h2345);
        send_pixel(16'hFFFF);
        program_stretch(16'h0000, 16'hFFFF, 16'h0000, 2'd3);
        send_pixel(16'h0042);
        send_pixel(16'h7000);
        program_stretch(16'h0000, 16'hFFFF, 16'hFFFF, SHAPE_LINEAR);
        send_pixel(16'hFFBD);
        send_pixel(16'h0100);
        // White equal to black: every pixel above black saturates.
        program_stretch(16'h8000, 16'h8000, 16'h8000, SHAPE_LINEAR);
        send_pixel(16'h8000);
        send_pixel(16'h8001);
        // Inverted window, and black at full scale.
        program_stretch(16'hC000, 16'h4000, 16'h3000, SHAPE_LOG);
        send_pixel(16'hC001);
        send_pixel(16'h1000);
        program_stretch(16'hFFFF, 16'h0000, 16'hFFFF, SHAPE_ASINH);
        send_pixel(16'hFFFF);
    endtask

    // Random settings per phase with random pixels; one phase runs with no
    // gaps on either side.
    task automatic test_random_stream();
        for (int phase = 0; phase < 14; phase++)
        begin
            logic [15:0] blk;
            logic [15:0] wht;
            blk = (phase % 5 == 0) ? 16'h0000 : 16'($urandom_range(16'h6000));
            wht = (phase % 5 == 1) ? 16'hFFFF : 16'($urandom_range(16'hFFFF, 16'h9000));
            if (phase % 7 == 3)
                wht = 16'($urandom);
            program_stretch(blk, wht, 16'($urandom), 2'(phase % 4));
            idle_on = (phase != 6);
            for (int n = 0; n < 50; n++)
                send_pixel(pick_pixel());
        end
        idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so
    // the pipeline fills and stops accepting input.
    task automatic test_output_stall();
        program_stretch(16'h0800, 16'hE000, 16'h2000, SHAPE_ASINH);
        hold_cycles = 300;
        for (int n = 0; n < 70; n++)
            send_pixel(pick_pixel());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 16'd0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_BLACK;
        cfg_wdata = 16'd0;
        idle_on   = 1'b1;
        hold_cycles = 0;
        mismatch_count = 0;
        black_q = 16'h0000;
        white_q = 16'hFFFF;
        mid_q   = 16'h8000;
        curve_q = SHAPE_LINEAR;
        build_curves();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_cases();
        test_random_stream();
        test_output_stall();
        drain_pipeline();

        if (mismatch_count == 0)
            $display("pixel_midtone_stretch_unit: match");
        else
            $display("pixel_midtone_stretch_unit: mismatch");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5ms;
        $display("pixel_midtone_stretch_unit: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pms_pkg.sv
hdl/pms_window.sv
hdl/pms_shape.sv
hdl/pms_mtf.sv
hdl/pixel_midtone_stretch_unit.sv
tb/tb_pixel_midtone_stretch_unit.sv
